### rtl/core/ppsch_pkg.sv
// ppsch_pkg: constants, structs and enums for the preemptive priority scheduler
// used by the channel interfaces, the table cell and the top level
package ppsch_pkg;

  localparam int unsigned MAX_PROCESSES = 16;
  localparam int unsigned IDX_W   = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int unsigned CNT_W   = $clog2(MAX_PROCESSES + 1);
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned SUM_W   = 48;
  localparam int unsigned ARR_W   = 16;
  localparam int unsigned BURST_W = 16;
  localparam int unsigned PRI_W   = 14;
  localparam int unsigned PID_W   = 5;
  localparam int unsigned PIDX_W  = (IDX_W + 1 > PID_W) ? IDX_W + 1 : PID_W;

  localparam logic [PRI_W-1:0] PRI_BOUND = 14'd9999;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_TICK = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               have;
    logic [IDX_W-1:0]   idx;
    logic [PRI_W-1:0]   pri;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] rem;
    logic [BURST_W-1:0] orig;
  } cand_t;

  typedef struct packed {
    logic               en;
    logic [IDX_W-1:0]   idx;
    logic [ARR_W-1:0]   arr;
    logic [BURST_W-1:0] burst;
    logic [PRI_W-1:0]   pri;
  } load_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } serve_t;

endpackage

### rtl/core/ppsch_if.sv
// ppsch_if: valid/ready channel interfaces for process loads, ticks and results
// depends on ppsch_pkg for field widths
interface ppsch_in_if;
  logic                               valid;
  logic                               ready;
  logic                               action;
  logic [ppsch_pkg::ARR_W-1:0]        arrival_time;
  logic [ppsch_pkg::BURST_W-1:0]      burst_length;
  logic [ppsch_pkg::PRI_W-1:0]        priority_level;

  modport source (output valid, action, arrival_time, burst_length, priority_level,
                  input ready);
  modport sink   (input valid, action, arrival_time, burst_length, priority_level,
                  output ready);
endinterface

interface ppsch_out_if;
  logic                          valid;
  logic                          ready;
  logic                          ran;
  logic [ppsch_pkg::PID_W-1:0]   process_id;
  logic [ppsch_pkg::TIME_W-1:0]  time_now;
  logic                          finished;
  logic [ppsch_pkg::TIME_W-1:0]  turnaround;
  logic [ppsch_pkg::TIME_W-1:0]  waiting;
  logic                          all_done;
  logic [ppsch_pkg::SUM_W-1:0]   total_turnaround;
  logic [ppsch_pkg::SUM_W-1:0]   total_waiting;

  modport source (output valid, ran, process_id, time_now, finished, turnaround, waiting,
                  all_done, total_turnaround, total_waiting, input ready);
  modport sink   (input valid, ran, process_id, time_now, finished, turnaround, waiting,
                  all_done, total_turnaround, total_waiting, output ready);
endinterface

### rtl/core/ppsch_cell.sv
// ppsch_cell: one process table entry plus one stage of the selection chain
// depends on ppsch_pkg
module ppsch_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ppsch_pkg::IDX_W-1:0]   idx_i,
  input  logic [ppsch_pkg::TIME_W-1:0]  time_i,
  input  ppsch_pkg::load_t              load_i,
  input  ppsch_pkg::serve_t             serve_i,
  input  ppsch_pkg::cand_t              cand_i,
  output ppsch_pkg::cand_t              cand_o
);

  logic                             loaded_q;
  logic [ppsch_pkg::ARR_W-1:0]      arr_q;
  logic [ppsch_pkg::BURST_W-1:0]    rem_q;
  logic [ppsch_pkg::BURST_W-1:0]    orig_q;
  logic [ppsch_pkg::PRI_W-1:0]      pri_q;
  ppsch_pkg::cand_t                 cand_q;
  ppsch_pkg::cand_t                 cand_d;
  logic                             eligible;
  logic                             take;

  always_comb begin
    eligible = loaded_q
               && ({{(ppsch_pkg::TIME_W - ppsch_pkg::ARR_W){1'b0}}, arr_q} <= time_i)
               && (rem_q != '0);
    take = eligible && ((pri_q < cand_i.pri)
                        || ((pri_q == cand_i.pri) && cand_i.have && (arr_q <= cand_i.arr)));
    if (take) begin
      cand_d = '{have: 1'b1, idx: idx_i, pri: pri_q, arr: arr_q, rem: rem_q, orig: orig_q};
    end else begin
      cand_d = cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loaded_q <= 1'b0;
      cand_q   <= '0;
    end else begin
      cand_q <= cand_d;
      if (load_i.en && (load_i.idx == idx_i)) begin
        loaded_q <= 1'b1;
      end
    end
  end

  // table entry
  always_ff @(posedge clk_i) begin
    if (load_i.en && (load_i.idx == idx_i)) begin
      arr_q  <= load_i.arr;
      rem_q  <= load_i.burst;
      orig_q <= load_i.burst;
      pri_q  <= load_i.pri;
    end else if (serve_i.en && (serve_i.idx == idx_i)) begin
      rem_q <= rem_q - ppsch_pkg::BURST_W'(1);
    end
  end

  assign cand_o = cand_q;

endmodule

### rtl/core/preemptive_priority_scheduler.sv
// preemptive_priority_scheduler: top level, chain of table cells plus tick control
// depends on ppsch_pkg, ppsch_if and ppsch_cell
//
//  channel     dir  transaction
//  in_chan_i   in   load a process (action 0) or advance one tick (action 1)
//  out_chan_o  out  one result per tick, none per load
//
// a load writes the next free table cell; after a tick is accepted the candidate
// travels one cell per cycle down the chain in the scan state, then the calc state does
// service and time update and the emit state does total update into the output register;
// the next transaction is taken once the control is back in the idle state
// reset clears counters, time, totals and the valid flags of the cells
// a held result stalls a following tick in its final stage; input is taken only when idle
module preemptive_priority_scheduler (
  input  logic      clk_i,
  input  logic      rst_ni,
  ppsch_in_if.sink  in_chan_i,
  ppsch_out_if.source out_chan_o
);

  localparam int unsigned N = ppsch_pkg::MAX_PROCESSES;

  ppsch_pkg::state_e                 state_q, state_d;
  logic [ppsch_pkg::IDX_W-1:0]       cnt_q, cnt_d;
  logic [ppsch_pkg::CNT_W-1:0]       loaded_q, loaded_d;
  logic [ppsch_pkg::CNT_W-1:0]       done_q, done_d;
  logic                              ticked_q, ticked_d;
  logic [ppsch_pkg::TIME_W-1:0]      time_q, time_d, time_next;
  logic [ppsch_pkg::SUM_W-1:0]       tsum_q, tsum_d, wsum_q, wsum_d;
  logic                              have_q, have_d, fin_q, fin_d;
  logic [ppsch_pkg::PID_W-1:0]       pid_q, pid_d;
  logic [ppsch_pkg::TIME_W-1:0]      tat_q, tat_d, wt_q, wt_d;
  logic                              out_valid_q, out_valid_d;
  logic                              o_ran_q, o_fin_q, o_all_q;
  logic [ppsch_pkg::PID_W-1:0]       o_pid_q;
  logic [ppsch_pkg::TIME_W-1:0]      o_time_q, o_tat_q, o_wt_q;
  logic                              emit;
  logic                              in_acc;
  logic [ppsch_pkg::ARR_W:0]         arr_orig;
  logic [ppsch_pkg::TIME_W:0]        wt_diff;
  logic [ppsch_pkg::SUM_W:0]         tsum_add, wsum_add;
  ppsch_pkg::load_t                  load;
  ppsch_pkg::serve_t                 serve;
  ppsch_pkg::cand_t                  chain [N+1];
  ppsch_pkg::cand_t                  best;

  assign chain[0] = '{have: 1'b0, idx: '0, pri: ppsch_pkg::PRI_BOUND, arr: '0,
                      rem: '0, orig: '0};

  for (genvar k = 0; k < N; k++) begin : g_cell
    ppsch_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (ppsch_pkg::IDX_W'(k)),
      .time_i  (time_q),
      .load_i  (load),
      .serve_i (serve),
      .cand_i  (chain[k]),
      .cand_o  (chain[k+1])
    );
  end

  assign best = chain[N];

  assign in_chan_i.ready = (state_q == ppsch_pkg::ST_IDLE);
  assign in_acc = in_chan_i.valid && in_chan_i.ready;

  always_comb begin
    load.en    = in_acc && (in_chan_i.action == ppsch_pkg::ACT_LOAD) && !ticked_q
                 && (loaded_q < ppsch_pkg::CNT_W'(N));
    load.idx   = loaded_q[ppsch_pkg::IDX_W-1:0];
    load.arr   = in_chan_i.arrival_time;
    load.burst = in_chan_i.burst_length;
    load.pri   = in_chan_i.priority_level;
    serve.en   = (state_q == ppsch_pkg::ST_CALC) && best.have;
    serve.idx  = best.idx;
  end

  always_comb begin
    time_next = (time_q == '1) ? time_q : time_q + ppsch_pkg::TIME_W'(1);
    arr_orig  = {1'b0, best.arr} + {1'b0, best.orig};
    wt_diff   = {1'b0, time_next}
                - {{(ppsch_pkg::TIME_W - ppsch_pkg::ARR_W){1'b0}}, arr_orig};
    tsum_add  = {1'b0, tsum_q} + {{(ppsch_pkg::SUM_W - ppsch_pkg::TIME_W + 1){1'b0}}, tat_q};
    wsum_add  = {1'b0, wsum_q} + {{(ppsch_pkg::SUM_W - ppsch_pkg::TIME_W + 1){1'b0}}, wt_q};
    emit      = (state_q == ppsch_pkg::ST_EMIT) && (!out_valid_q || out_chan_o.ready);
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    loaded_d    = loaded_q;
    done_d      = done_q;
    ticked_d    = ticked_q;
    time_d      = time_q;
    tsum_d      = tsum_q;
    wsum_d      = wsum_q;
    have_d      = have_q;
    fin_d       = fin_q;
    pid_d       = pid_q;
    tat_d       = tat_q;
    wt_d        = wt_q;
    out_valid_d = out_valid_q && !out_chan_o.ready;
    unique case (state_q)
      ppsch_pkg::ST_IDLE: begin
        if (load.en) begin
          loaded_d = loaded_q + ppsch_pkg::CNT_W'(1);
        end
        if (in_acc && (in_chan_i.action == ppsch_pkg::ACT_TICK)) begin
          ticked_d = 1'b1;
          cnt_d    = '0;
          state_d  = ppsch_pkg::ST_SCAN;
        end
      end
      ppsch_pkg::ST_SCAN: begin
        cnt_d = cnt_q + ppsch_pkg::IDX_W'(1);
        if (cnt_q == ppsch_pkg::IDX_W'(N - 1)) begin
          state_d = ppsch_pkg::ST_CALC;
        end
      end
      ppsch_pkg::ST_CALC: begin
        time_d = time_next;
        have_d = best.have;
        fin_d  = best.have && (best.rem == ppsch_pkg::BURST_W'(1));
        pid_d  = best.have
                 ? ppsch_pkg::PID_W'(ppsch_pkg::PIDX_W'(best.idx) + ppsch_pkg::PIDX_W'(1))
                 : '0;
        if (fin_d) begin
          tat_d  = time_next - {{(ppsch_pkg::TIME_W - ppsch_pkg::ARR_W){1'b0}}, best.arr};
          wt_d   = wt_diff[ppsch_pkg::TIME_W] ? '0 : wt_diff[ppsch_pkg::TIME_W-1:0];
          done_d = done_q + ppsch_pkg::CNT_W'(1);
        end else begin
          tat_d = '0;
          wt_d  = '0;
        end
        state_d = ppsch_pkg::ST_EMIT;
      end
      ppsch_pkg::ST_EMIT: begin
        if (emit) begin
          tsum_d      = tsum_add[ppsch_pkg::SUM_W] ? '1 : tsum_add[ppsch_pkg::SUM_W-1:0];
          wsum_d      = wsum_add[ppsch_pkg::SUM_W] ? '1 : wsum_add[ppsch_pkg::SUM_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ppsch_pkg::ST_IDLE;
        end
      end
      default: state_d = ppsch_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ppsch_pkg::ST_IDLE;
      cnt_q       <= '0;
      loaded_q    <= '0;
      done_q      <= '0;
      ticked_q    <= 1'b0;
      time_q      <= '0;
      tsum_q      <= '0;
      wsum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      loaded_q    <= loaded_d;
      done_q      <= done_d;
      ticked_q    <= ticked_d;
      time_q      <= time_d;
      tsum_q      <= tsum_d;
      wsum_q      <= wsum_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per-tick working values and output payload
  always_ff @(posedge clk_i) begin
    have_q <= have_d;
    fin_q  <= fin_d;
    pid_q  <= pid_d;
    tat_q  <= tat_d;
    wt_q   <= wt_d;
    if (emit) begin
      o_ran_q  <= have_q;
      o_pid_q  <= pid_q;
      o_time_q <= time_q;
      o_fin_q  <= fin_q;
      o_tat_q  <= tat_q;
      o_wt_q   <= wt_q;
      o_all_q  <= (done_q == loaded_q);
    end
  end

  assign out_chan_o.valid            = out_valid_q;
  assign out_chan_o.ran              = o_ran_q;
  assign out_chan_o.process_id       = o_pid_q;
  assign out_chan_o.time_now         = o_time_q;
  assign out_chan_o.finished         = o_fin_q;
  assign out_chan_o.turnaround       = o_tat_q;
  assign out_chan_o.waiting          = o_wt_q;
  assign out_chan_o.all_done         = o_all_q;
  assign out_chan_o.total_turnaround = tsum_q;
  assign out_chan_o.total_waiting    = wsum_q;

endmodule
